### rtl/histogram_equalizer_macros.svh
// Assertion macros for the histogram equaliser RTL.
`ifndef HISTOGRAM_EQUALIZER_MACROS_SVH
`define HISTOGRAM_EQUALIZER_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset.
`define HEQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check that a condition never holds outside reset.
`define HEQ_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define HEQ_ASSERT(label, clk, rst_n, prop)
`define HEQ_NEVER(label, clk, rst_n, expr)

`endif

`endif

### rtl/hiseq_pkg.sv
package hiseq_pkg;

    localparam int unsigned BIN_COUNT_DEF       = 65536;
    localparam int unsigned MAX_PIXELS_LOG2_DEF = 24;
    localparam int unsigned PIXEL_W             = 16;
    localparam int unsigned FIFO_DEPTH          = 4;

    // Opcodes of an input transaction
    localparam logic OP_COUNT = 1'b0;
    localparam logic OP_MAP   = 1'b1;

    // Pixel depth modes
    localparam logic MODE_8BIT  = 1'b0;
    localparam logic MODE_16BIT = 1'b1;

    localparam logic [PIXEL_W-1:0] MAXVAL_8BIT  = 16'h00FF;
    localparam logic [PIXEL_W-1:0] MAXVAL_16BIT = 16'hFFFF;

    typedef struct packed {
        logic               opcode;
        logic [PIXEL_W-1:0] pixel;
        logic               last_of_pass;
    } t_in;

    typedef struct packed {
        logic [PIXEL_W-1:0] mapped_pixel;
        logic               last_out;
    } t_out;

    // Classified item handed from front to back
    typedef struct packed {
        logic               op;
        logic               mode;
        logic [PIXEL_W-1:0] idx;
        logic               last;
    } t_job;

endpackage

### rtl/hiseq_ram.sv
module hiseq_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port, and registered read held between reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/hiseq_front.sv
module hiseq_front
    import hiseq_pkg::*;
#(
    parameter int unsigned BIN_COUNT = BIN_COUNT_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_mode,
    input  logic i_valid,
    input  t_in  i_data,
    output logic o_stall,
    output logic o_head_valid,
    output t_job o_head,
    input  logic i_pop
);

    localparam int unsigned PW = $clog2(FIFO_DEPTH);

    t_job             r_mem [FIFO_DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [PW:0]      r_cnt;
    logic             push;
    logic             pop;
    t_job             n_job;
    logic [PIXEL_W-1:0] clamped;

    // Clamp a 16-bit pixel to the last bin
    always_comb begin
        if ({1'b0, i_data.pixel} >= (PIXEL_W+1)'(BIN_COUNT)) begin
            clamped = PIXEL_W'(BIN_COUNT - 1);
        end else begin
            clamped = i_data.pixel;
        end
    end

    // Classify the transaction into a bin index under the current mode
    always_comb begin
        n_job.op   = i_data.opcode;
        n_job.mode = i_mode;
        n_job.last = i_data.last_of_pass;
        if (i_mode == MODE_8BIT) begin
            n_job.idx = {8'd0, i_data.pixel[7:0]};
        end else begin
            n_job.idx = clamped;
        end
    end

    assign o_stall      = (r_cnt == (PW+1)'(FIFO_DEPTH));
    assign push         = i_valid && !o_stall;
    assign o_head_valid = (r_cnt != '0);
    assign pop          = i_pop && o_head_valid;
    assign o_head       = r_mem[r_rp];

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= n_job;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PW'(FIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == PW'(FIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

endmodule

### rtl/hiseq_back.sv
`include "histogram_equalizer_macros.svh"

module hiseq_back
    import hiseq_pkg::*;
#(
    parameter int unsigned BIN_COUNT = BIN_COUNT_DEF,
    parameter int unsigned CW        = MAX_PIXELS_LOG2_DEF + 1
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_head_valid,
    input  t_job i_head,
    output logic o_pop,
    output logic o_valid,
    output t_out o_data,
    input  logic i_stall
);

    localparam int unsigned IW = $clog2(BIN_COUNT);
    localparam int unsigned NW = CW + 18;
    localparam int unsigned RW = CW + 2;
    localparam int unsigned PRW = CW + 16;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CNT_WR, S_MAP_OUT, S_SCAN_RD, S_SCAN_CHK,
        S_FILL, S_ACC_RD, S_ACC, S_MUL, S_NUM, S_DIV, S_WR
    } t_state;

    t_state          r_state;
    t_job            r_job;
    logic [IW-1:0]   r_a;
    logic            r_mode;
    logic [CW-1:0]   r_total;
    logic [IW-1:0]   r_m;
    logic [CW-1:0]   r_den;
    logic [CW:0]     r_cum;
    logic            r_sat;
    logic [PRW-1:0]  r_prod;
    logic [NW-1:0]   r_num;
    logic [RW-1:0]   r_rem;
    logic [15:0]     r_q;
    logic [3:0]      r_cnt;
    logic            r_ov;
    t_out            r_out;

    logic [IW-1:0]   last_a;
    logic [15:0]     maxval;
    logic [CW-1:0]   bin_rd;
    logic [15:0]     map_rd;
    logic [CW-1:0]   bin_inc;
    logic            bin_we, bin_re, map_we, map_re;
    logic [IW-1:0]   bin_waddr, bin_raddr, map_waddr;
    logic [CW-1:0]   bin_wdata;
    logic [15:0]     map_wdata;
    logic [NW-1:0]   n_num;
    logic [CW:0]     divisor;
    logic [RW:0]     trial;
    logic            ge;
    logic [RW-1:0]   n_rem;
    logic            out_free;

    assign last_a   = (r_mode == MODE_16BIT) ? IW'(BIN_COUNT - 1) : IW'(255);
    assign maxval   = (r_mode == MODE_16BIT) ? MAXVAL_16BIT : MAXVAL_8BIT;
    assign bin_inc  = (bin_rd == '1) ? bin_rd : bin_rd + 1'b1;
    assign o_pop    = (r_state == S_IDLE) && i_head_valid;
    assign out_free = !r_ov || !i_stall;

    // Bin memory port control
    always_comb begin
        bin_re    = (o_pop && i_head.op == OP_COUNT) || r_state == S_SCAN_RD
                    || r_state == S_ACC_RD;
        bin_raddr = (r_state == S_IDLE) ? i_head.idx[IW-1:0] : r_a;
        bin_we    = (r_state == S_CNT_WR) || (r_state == S_CLEAR);
        bin_waddr = (r_state == S_CNT_WR) ? r_job.idx[IW-1:0] : r_a;
        bin_wdata = (r_state == S_CNT_WR) ? bin_inc : '0;
    end

    // Table memory port control
    always_comb begin
        map_re    = o_pop && i_head.op == OP_MAP;
        map_we    = (r_state == S_SCAN_CHK) || (r_state == S_FILL) || (r_state == S_WR);
        map_waddr = r_a;
        unique case (r_state)
            S_FILL:  map_wdata = 16'(r_m);
            S_WR:    map_wdata = r_sat ? maxval : r_q;
            default: map_wdata = '0;
        endcase
    end

    // One restoring division step per cycle
    always_comb begin
        n_num   = NW'({r_prod, 1'b0}) + NW'(r_den);
        divisor = {r_den, 1'b0};
        trial   = {r_rem, r_num[4'd15 - r_cnt]};
        ge      = trial >= (RW+1)'(divisor);
        n_rem   = ge ? RW'(trial - (RW+1)'(divisor)) : RW'(trial);
    end

    hiseq_ram #(.WIDTH(CW), .DEPTH(BIN_COUNT)) u_bins (
        .i_clk   (i_clk),
        .i_we    (bin_we),
        .i_waddr (bin_waddr),
        .i_wdata (bin_wdata),
        .i_re    (bin_re),
        .i_raddr (bin_raddr),
        .o_rdata (bin_rd)
    );

    hiseq_ram #(.WIDTH(16), .DEPTH(BIN_COUNT)) u_table (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (map_re),
        .i_raddr (i_head.idx[IW-1:0]),
        .o_rdata (map_rd)
    );

    // Sequencer: count, map, table build and histogram clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_a     <= '0;
            r_total <= '0;
            r_ov    <= 1'b0;
            r_sat   <= 1'b0;
            r_mode  <= MODE_8BIT;
            r_cnt   <= '0;
        end else begin
            // Drop the result once taken, unless a new one replaces it
            if (r_ov && !i_stall && (r_state != S_MAP_OUT)) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_total <= '0;
                    if (r_a == IW'(BIN_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_a <= r_a + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_head_valid) begin
                        r_job   <= i_head;
                        r_state <= (i_head.op == OP_COUNT) ? S_CNT_WR : S_MAP_OUT;
                    end
                end
                S_CNT_WR: begin
                    if (r_total != '1) begin
                        r_total <= r_total + 1'b1;
                    end
                    if (r_job.last) begin
                        r_mode  <= r_job.mode;
                        r_a     <= '0;
                        r_state <= S_SCAN_RD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_MAP_OUT: begin
                    if (out_free) begin
                        r_ov               <= 1'b1;
                        r_out.mapped_pixel <= map_rd;
                        r_out.last_out     <= r_job.last;
                        if (r_job.last) begin
                            r_a     <= '0;
                            r_state <= S_CLEAR;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_SCAN_RD: begin
                    r_state <= S_SCAN_CHK;
                end
                S_SCAN_CHK: begin
                    if (bin_rd != '0) begin
                        r_m   <= r_a;
                        r_den <= r_total - bin_rd;
                        r_cum <= '0;
                        r_sat <= 1'b0;
                        if (bin_rd >= r_total) begin
                            r_a     <= '0;
                            r_state <= S_FILL;
                        end else if (r_a == last_a) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_a     <= r_a + 1'b1;
                            r_state <= S_ACC_RD;
                        end
                    end else if (r_a == last_a) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_a     <= r_a + 1'b1;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_FILL: begin
                    if (r_a == last_a) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_a <= r_a + 1'b1;
                    end
                end
                S_ACC_RD: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (!r_sat) begin
                        r_cum <= r_cum + (CW+1)'(bin_rd);
                    end
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_sat   <= r_sat || (r_cum >= {1'b0, r_den});
                    r_prod  <= PRW'(r_cum[CW-1:0]) * PRW'(maxval);
                    r_state <= S_NUM;
                end
                S_NUM: begin
                    r_num   <= n_num;
                    r_rem   <= RW'(n_num >> 16);
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_q   <= {r_q[14:0], ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 4'd15) begin
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    if (r_a == last_a) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_a     <= r_a + 1'b1;
                        r_state <= S_ACC_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

    `HEQ_NEVER(a_pop_only_idle, i_clk, i_rst_n, o_pop && (r_state != S_IDLE))
    `HEQ_ASSERT(a_cum_below_den, i_clk, i_rst_n, (r_state == S_ACC_RD) |-> (r_sat || (r_cum < {1'b0, r_den})))
    `HEQ_ASSERT(a_rem_below_div, i_clk, i_rst_n, ((r_state == S_DIV) && !r_sat) |-> (r_rem < RW'(divisor)))
    `HEQ_ASSERT(a_out_held, i_clk, i_rst_n, (r_ov && i_stall) |=> (r_ov && $stable(r_out)))

endmodule

### rtl/histogram_equalizer.sv
// Histogram equaliser. Feed each frame twice: a count pass (opcode count) and then a map
// pass (opcode map), each ending with last_of_pass. Every map transaction yields one
// result; count transactions yield none. Items are queued in a four-entry front queue and
// executed one at a time by a sequencer around two single-port-pair RAMs (bins and table).
// A count or map item is a RAM read, then an update or output; a map item waits in its
// output step while the previous result is held by output stall. The item ending the
// count pass builds the table: a read and a check per empty bin below the first occupied
// one, then per remaining bin accumulate, multiply, a 16-step divider and a write, or a
// single write per bin when one bin holds every pixel. After reset and after the last
// map item of a frame all BIN_COUNT histogram bins are cleared, while no item executes.
// depth_mode may be written only while the block is idle.
module histogram_equalizer
    import hiseq_pkg::*;
#(
    parameter int unsigned BIN_COUNT       = BIN_COUNT_DEF,
    parameter int unsigned MAX_PIXELS_LOG2 = MAX_PIXELS_LOG2_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_data,
    input  logic i_in_valid,
    input  t_in  i_in_data,
    output logic o_in_stall,
    output logic o_out_valid,
    output t_out o_out_data,
    input  logic i_out_stall
);

    logic r_mode;
    logic head_valid;
    t_job head;
    logic pop;

    // Hold the depth mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_8BIT;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    hiseq_front #(.BIN_COUNT(BIN_COUNT)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode       (r_mode),
        .i_valid      (i_in_valid),
        .i_data       (i_in_data),
        .o_stall      (o_in_stall),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    hiseq_back #(.BIN_COUNT(BIN_COUNT), .CW(MAX_PIXELS_LOG2 + 1)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_out_valid),
        .o_data       (o_out_data),
        .i_stall      (i_out_stall)
    );

endmodule
